// File: rtl/core/rme_pkg.sv
// Shared types and constants of the rotation matrix to Euler angle unit.
package rme_pkg;

    localparam int TAB_LEN    = 24;
    localparam int IN_W       = 16;
    localparam int OP_W       = 18;
    localparam int ANG_W      = 15;
    localparam int ACC_W      = 32;
    localparam int SQ_W       = 32;
    localparam int ROOT_STEPS = 16;
    localparam int DEG_LIMIT  = 11520;

    // atan(2^-i) in degrees, scaled by 2^22, rounded to nearest
    localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    // 90 degrees in accumulator units
    localparam logic signed [ACC_W-1:0] ACC_90 = 32'sd377487360;

    typedef struct packed {
        logic signed [IN_W-1:0] r00;
        logic signed [IN_W-1:0] r10;
        logic signed [IN_W-1:0] r20;
        logic signed [IN_W-1:0] r21;
        logic signed [IN_W-1:0] r22;
        logic signed [IN_W-1:0] r11;
        logic signed [IN_W-1:0] r12;
    } rme_mat_t;

endpackage

// File: rtl/core/rotation_matrix_to_euler_unit.sv
// Top level: rotation matrix to x-y-z Euler angles, fully pipelined.
//
//   channel   signals                                        transfer when
//   input     in_valid in_ready r00 r10 r20 r21 r22 r11 r12  in_valid & in_ready
//   output    out_valid out_ready roll_deg pitch_deg         out_valid & out_ready
//             yaw_deg is_singular
//   config    cfg_we cfg_data                                cfg_we
//
// One matrix enters per cycle while the output is not held. A result passes the square-root pipe
// (squares, sum, 16 root stages), a select register and the atan2 pipes
// (fold, micro-rotations, rounding).
// Reset clears all valid bits and sets the threshold to 1.
// When the output holds and is not taken, the whole pipe holds.
module rotation_matrix_to_euler_unit
    import rme_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  r00,
    input  logic signed [IN_W-1:0]  r10,
    input  logic signed [IN_W-1:0]  r20,
    input  logic signed [IN_W-1:0]  r21,
    input  logic signed [IN_W-1:0]  r22,
    input  logic signed [IN_W-1:0]  r11,
    input  logic signed [IN_W-1:0]  r12,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ANG_W-1:0] roll_deg,
    output logic signed [ANG_W-1:0] pitch_deg,
    output logic signed [ANG_W-1:0] yaw_deg,
    output logic                    is_singular,
    input  logic                    cfg_we,
    input  logic [7:0]              cfg_data
);

    localparam int NSTEP   = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int COR_LAT = NSTEP + 2;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // threshold register
    logic [7:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // square root pipe
    rme_mat_t              mat_in;
    rme_mat_t              mat_sq;
    logic                  sq_valid;
    logic [ROOT_STEPS-1:0] sy;

    assign mat_in = '{r00: r00, r10: r10, r20: r20, r21: r21,
                      r22: r22, r11: r11, r12: r12};

    rme_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .mat_in    (mat_in),
        .out_valid (sq_valid),
        .mat_out   (mat_sq),
        .sy        (sy)
    );

    // pick formulas and operands
    logic                   sel_v_reg;
    logic                   sel_s_reg;
    logic signed [OP_W-1:0] roll_y_reg;
    logic signed [OP_W-1:0] roll_x_reg;
    logic signed [OP_W-1:0] yaw_y_reg;
    logic signed [OP_W-1:0] yaw_x_reg;
    logic signed [OP_W-1:0] pit_y_reg;
    logic signed [OP_W-1:0] pit_x_reg;
    logic                   sing;

    assign sing = sy < ROOT_STEPS'(thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_v_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_s_reg <= sing;
            pit_y_reg <= -OP_W'(mat_sq.r20);
            pit_x_reg <= OP_W'({2'b00, sy});
            if (sing)
            begin
                roll_y_reg <= -OP_W'(mat_sq.r12);
                roll_x_reg <= OP_W'(mat_sq.r11);
                yaw_y_reg  <= '0;
                yaw_x_reg  <= '0;
            end
            else
            begin
                roll_y_reg <= OP_W'(mat_sq.r21);
                roll_x_reg <= OP_W'(mat_sq.r22);
                yaw_y_reg  <= OP_W'(mat_sq.r10);
                yaw_x_reg  <= OP_W'(mat_sq.r00);
            end
        end
    end

    // three atan2 pipes side by side
    logic roll_v;
    logic pit_v;
    logic yaw_v;

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (sel_v_reg),
        .y_in (roll_y_reg), .x_in (roll_x_reg),
        .out_valid (roll_v), .angle (roll_deg)
    );

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (sel_v_reg),
        .y_in (pit_y_reg), .x_in (pit_x_reg),
        .out_valid (pit_v), .angle (pitch_deg)
    );

    rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (sel_v_reg),
        .y_in (yaw_y_reg), .x_in (yaw_x_reg),
        .out_valid (yaw_v), .angle (yaw_deg)
    );

    // delay the singular flag alongside the atan2 pipes
    logic sflag_reg [COR_LAT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sflag_reg[0] <= sel_s_reg;
            for (int i = 1; i < COR_LAT; i++)
            begin
                sflag_reg[i] <= sflag_reg[i-1];
            end
        end
    end

    assign out_valid   = pit_v;
    assign is_singular = sflag_reg[COR_LAT-1];

    // checks
    a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (roll_v == pit_v) && (yaw_v == pit_v))
        else $error("atan2 pipes out of step");

    a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_singular) |-> (yaw_deg == '0))
        else $error("yaw not zero in singular case");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pitch_deg)
                                       && $stable(roll_deg)))
        else $error("held result changed");

endmodule

// File: rtl/core/rme_sqrt.sv
// Pipelined sy = isqrt(r00^2 + r10^2), one result bit per stage, matrix carried along.
module rme_sqrt
    import rme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  rme_mat_t              mat_in,
    output logic                  out_valid,
    output rme_mat_t              mat_out,
    output logic [ROOT_STEPS-1:0] sy
);

    logic                 sq_v_reg;
    logic signed [31:0]   sq_a_reg;
    logic signed [31:0]   sq_b_reg;
    rme_mat_t             sq_m_reg;

    logic                 sum_v_reg;
    logic [SQ_W-1:0]      sum_reg;
    rme_mat_t             sum_m_reg;

    logic                 rv_reg  [ROOT_STEPS];
    logic [SQ_W-1:0]      rem_reg [ROOT_STEPS];
    logic [SQ_W-1:0]      res_reg [ROOT_STEPS];
    rme_mat_t             rm_reg  [ROOT_STEPS];

    // square both column entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a_reg <= mat_in.r00 * mat_in.r00;
            sq_b_reg <= mat_in.r10 * mat_in.r10;
            sq_m_reg <= mat_in;
        end
    end

    // add the squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= SQ_W'(sq_a_reg[30:0]) + SQ_W'(sq_b_reg[30:0]);
            sum_m_reg <= sq_m_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (30 - 2 * k);
        logic            v_in;
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        rme_mat_t        m_in;
        logic [SQ_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign v_in   = sum_v_reg;
            assign rem_in = sum_reg;
            assign res_in = '0;
            assign m_in   = sum_m_reg;
        end
        else
        begin : g_next
            assign v_in   = rv_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign m_in   = rm_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                rv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rm_reg[k] <= m_in;
                if (rem_in >= trial)
                begin
                    rem_reg[k] <= rem_in - trial;
                    res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign out_valid = rv_reg[ROOT_STEPS-1];
    assign mat_out   = rm_reg[ROOT_STEPS-1];
    assign sy        = res_reg[ROOT_STEPS-1][ROOT_STEPS-1:0];

endmodule

// File: rtl/core/rme_cordic.sv
// Pipelined vectoring CORDIC atan2 with degree output in 1/64 degree.
module rme_cordic
    import rme_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [OP_W-1:0]  y_in,
    input  logic signed [OP_W-1:0]  x_in,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] angle
);

    localparam int N  = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
    localparam int CW = 38;

    logic                    v_reg   [N+1];
    logic                    z_reg   [N+1];
    logic signed [CW-1:0]    x_reg   [N+1];
    logic signed [CW-1:0]    y_reg   [N+1];
    logic signed [ACC_W-1:0] acc_reg [N+1];

    logic                    ov_reg;
    logic signed [ANG_W-1:0] ang_reg;

    // quadrant fold into x >= 0
    logic signed [OP_W-1:0]  px;
    logic signed [OP_W-1:0]  py;
    logic signed [ACC_W-1:0] pacc;

    always_comb
    begin
        px   = x_in;
        py   = y_in;
        pacc = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                px   = y_in;
                py   = -x_in;
                pacc = ACC_90;
            end
            else
            begin
                px   = -y_in;
                py   = x_in;
                pacc = -ACC_90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= (x_in == 0) && (y_in == 0);
            x_reg[0]   <= {{(CW-OP_W-16){px[OP_W-1]}}, px, 16'b0};
            y_reg[0]   <= {{(CW-OP_W-16){py[OP_W-1]}}, py, 16'b0};
            acc_reg[0] <= pacc;
        end
    end

    // micro-rotations, one per stage
    for (genvar k = 1; k <= N; k++)
    begin : g_iter
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[k-1] >>> (k - 1);
        assign dy = x_reg[k-1] >>> (k - 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[k] <= z_reg[k-1];
                if (y_reg[k-1] >= 0)
                begin
                    x_reg[k]   <= x_reg[k-1] + dx;
                    y_reg[k]   <= y_reg[k-1] - dy;
                    acc_reg[k] <= acc_reg[k-1] + ATAN_TAB[k-1];
                end
                else
                begin
                    x_reg[k]   <= x_reg[k-1] - dx;
                    y_reg[k]   <= y_reg[k-1] + dy;
                    acc_reg[k] <= acc_reg[k-1] - ATAN_TAB[k-1];
                end
            end
        end
    end

    // round to 1/64 degree and clamp
    logic signed [ACC_W:0]   rsum;
    logic signed [ACC_W-16:0] rq;
    logic signed [ANG_W-1:0] rnext;

    always_comb
    begin
        rsum = {acc_reg[N][ACC_W-1], acc_reg[N]} + (ACC_W+1)'(32768);
        rq   = rsum[ACC_W:16];
        if (z_reg[N])
        begin
            rnext = '0;
        end
        else if (rq > (ACC_W-15)'(DEG_LIMIT))
        begin
            rnext = ANG_W'(DEG_LIMIT);
        end
        else if (rq < -(ACC_W-15)'(DEG_LIMIT))
        begin
            rnext = -ANG_W'(DEG_LIMIT);
        end
        else
        begin
            rnext = rq[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= rnext;
        end
    end

    assign out_valid = ov_reg;
    assign angle     = ang_reg;

endmodule

// File: tb/sv/tb.sv
// Testbench for the rotation matrix to Euler angle unit.
`timescale 1ns / 100ps

module tb;
    import rme_pkg::*;

    localparam int STEPS    = 16;
    localparam int LATENCY  = 37;
    localparam int N_RANDOM = 830;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic                    sing;
    } angles_t;

    typedef struct {
        rme_mat_t m;
        bit       known;
        angles_t  a;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [IN_W-1:0] r00 = '0, r10 = '0, r20 = '0, r21 = '0;
    logic signed [IN_W-1:0] r22 = '0, r11 = '0, r12 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ANG_W-1:0] roll_deg, pitch_deg, yaw_deg;
    logic is_singular;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    logic [7:0] threshold;
    angles_t    pending_angles[$];
    int         n_errors = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    rotation_matrix_to_euler_unit #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22), .r11(r11), .r12(r12),
        .out_valid(out_valid), .out_ready(out_ready),
        .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
        .is_singular(is_singular),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Vectoring CORDIC atan2, result in 1/64 degree
    function automatic logic signed [ANG_W-1:0] cordic_atan2(longint y, longint x);
        longint cx, cy, acc, t, dx, dy, r;
        int n;
        acc = 0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; acc = longint'(ACC_90);
            end
            else
            begin
                x = -y; y = t; acc = -longint'(ACC_90);
            end
        end
        cx = x * 65536;
        cy = y * 65536;
        n = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
        for (int i = 0; i < n; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx; cy -= dy; acc += longint'(ATAN_TAB[i]);
            end
            else
            begin
                cx -= dx; cy += dy; acc -= longint'(ATAN_TAB[i]);
            end
        end
        r = (acc + 32768) >>> 16;
        if (r > DEG_LIMIT) r = DEG_LIMIT;
        if (r < -DEG_LIMIT) r = -DEG_LIMIT;
        return r[ANG_W-1:0];
    endfunction

    // Root of a sum of two squares stays below 2^16
    function automatic longint int_sqrt(longint v);
        longint s;
        s = 0;
        for (longint b = 64'sd1 <<< 16; b > 0; b = b >>> 1)
            if ((s + b) * (s + b) <= v)
                s += b;
        return s;
    endfunction

    function automatic angles_t euler_of(rme_mat_t m);
        angles_t a;
        longint sy;
        sy = int_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
        a.sing = sy < longint'(threshold);
        if (a.sing)
        begin
            a.roll = cordic_atan2(-longint'(m.r12), m.r11);
            a.yaw  = '0;
        end
        else
        begin
            a.roll = cordic_atan2(m.r21, m.r22);
            a.yaw  = cordic_atan2(m.r10, m.r00);
        end
        a.pitch = cordic_atan2(-longint'(m.r20), sy);
        return a;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return IN_W'(16384);
            1: return -IN_W'(16384);
            2: return IN_W'($urandom_range(0, 8) - 4);
            3: return IN_W'($urandom);
            default: return IN_W'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Random burst of idle cycles, none near the end
    task automatic idle_burst(bit late);
        if (!late && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Present one matrix and hold it until the transfer; valid stays up for the next one
    task automatic send_matrix(rme_mat_t m, bit late);
        idle_burst(late);
        pending_angles.insert(pending_angles.size(), euler_of(m));
        {r00, r10, r20, r21, r22, r11, r12} <= m;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_angles.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        threshold = v;
    endtask

    // Receiver stall pattern: random bursts of stall
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            out_ready <= 1'b1;
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        angles_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{roll_deg, pitch_deg, yaw_deg, is_singular};
            if (pending_angles.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        rme_mat_t m;
        logic [7:0] thr_list[5];
        logic [IN_W-1:0] c;
        thr_list = '{8'd0, 8'd255, 8'd40, 8'd1, 8'd128};
        threshold = 8'd1;

        // Directed table: identity, flips, extremes, singular cases
        rows.insert(rows.size(), '{'{16384, 0, 0, 0, 16384, 16384, 0}, 1, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1}});
        rows.insert(rows.size(), '{'{-16384, 0, 0, 0, -16384, 16384, 0}, 1,
                                   '{11520, 0, 11520, 0}});
        rows.insert(rows.size(), '{'{0, 0, -16384, 16384, 0, 16384, 0}, 0, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{0, 0, 16384, 0, 0, 0, -16384}, 0, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{0, 16384, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{0, -16384, 0, -16384, 0, 0, 0}, 0, '{0, 0, 0, 0}});
        rows.insert(rows.size(),
                    '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768},
                      0, '{0, 0, 0, 0}});
        rows.insert(rows.size(),
                    '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767},
                      0, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{-16384, -1, 5, -3, -16384, -16384, 7}, 0,
                                   '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, -16384, 0}, 0, '{0, 0, 0, 0}});
        rows.insert(rows.size(), '{'{11585, 11585, -11585, 8192, 14189, 0, 0}, 0,
                                   '{0, 0, 0, 0}});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_matrix(row.m, 1'b0);
            if (row.known && pending_angles[$] !== row.a)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("predictor off on row %0d: expected %p got %p",
                             i, row.a, pending_angles[$]);
            end
        end

        // Random phases, one per threshold setting
        foreach (thr_list[p])
        begin
            write_threshold(thr_list[p]);
            for (int k = 0; k < N_RANDOM / 5; k++)
            begin
                m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                     rand_entry(), rand_entry(), rand_entry()};
                if ($urandom_range(0, 3) == 0)
                begin
                    // near gimbal lock: tiny r00/r10
                    m.r00 = IN_W'(int'($urandom_range(0, 300)) - 150);
                    m.r10 = IN_W'(int'($urandom_range(0, 300)) - 150);
                end
                if (k == 20) drain();
                if (p == 4 && k > N_RANDOM / 10) quiet = 1'b1;
                send_matrix(m, quiet);
            end
        end

        // Toggle every input bit through both values
        for (int b = 0; b < IN_W; b++)
        begin
            c = IN_W'(1) << b;
            send_matrix({7{c}}, 1'b1);
            send_matrix({7{~c}}, 1'b1);
        end

        fork
            drain();
            begin
                #5_000_000;
            end
        join_any
        if (n_errors == 0 && pending_angles.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
